FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tt_pkg.sv
package tt_pkg;

    localparam int KEY_W      = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int USER_W     = 1;

    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GENERATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATE_THR   = 1'd1;

    localparam logic [7:0]  GEN_RESET     = 8'd0;
    localparam logic [14:0] MATE_THR_RESET = 15'd31900;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    typedef struct packed {
        logic               unsafe;
        logic signed [15:0] score_in;
        logic [15:0]        move_in;
        logic               on_pv;
        logic signed [15:0] beta;
        logic signed [15:0] alpha;
        logic [6:0]         ply;
        logic [5:0]         depth;
        logic [KEY_W-1:0]   key;
    } tt_req_t;

    typedef struct packed {
        logic               written;
        logic signed [15:0] cutoff_score;
        logic               cutoff;
        logic [15:0]        move_out;
        logic               move_valid;
        logic               key_match;
    } tt_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [15:0]        move;
        logic [5:0]         depth;
        logic [7:0]         gen;
        logic signed [15:0] score;
        logic [1:0]         bound;
    } tt_entry_t;

    typedef struct packed {
        logic [7:0]  generation;
        logic [14:0] mate_thr;
    } tt_cfg_t;

    localparam int REQ_W      = $bits(tt_req_t);
    localparam int RSP_W      = $bits(tt_rsp_t);
    localparam int S_TDATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RSP_W + 7) / 8) * 8;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: design/tt_index.sv
module tt_slot_map
    import tt_pkg::*;
#(
    parameter int ENTRIES = 16384,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [IDX_W-1:0] index
);

    localparam int DIGITS = KEY_W / 8;

    function automatic logic [DIGITS*IDX_W-1:0] digit_weights();
        logic [DIGITS*IDX_W-1:0] w;
        logic [63:0]             p;
        w = '0;
        p = 64'd1 % 64'(ENTRIES);
        for (int b = 0; b < DIGITS; b++) begin
            w[IDX_W*b +: IDX_W] = IDX_W'(p);
            p = (p << 8) % 64'(ENTRIES);
        end
        return w;
    endfunction

    generate
        if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
            logic             done_reg;
            logic [IDX_W-1:0] idx_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    idx_reg <= key[IDX_W-1:0];
                end
            end

            assign done  = done_reg;
            assign index = idx_reg;
        end else begin : g_fold
            // Each key byte is weighted by its place value modulo the table size.
            // The folded sum is then reduced by a reciprocal multiply, leaving a
            // remainder below twice the table size that one subtraction corrects.
            localparam int V_W = IDX_W + 8 + $clog2(DIGITS);
            localparam logic [DIGITS*IDX_W-1:0] WEIGHTS = digit_weights();
            localparam logic [V_W-1:0] RECIP = V_W'((64'd1 << V_W) / 64'(ENTRIES));

            logic             s1_reg;
            logic             s2_reg;
            logic             s3_reg;
            logic             done_reg;
            logic [V_W-1:0]   fold_next;
            logic [V_W-1:0]   fold_reg;
            logic [2*V_W-1:0] prod;
            logic [V_W-1:0]   quot_next;
            logic [V_W-1:0]   quot_reg;
            logic [V_W-1:0]   qm;
            logic [IDX_W:0]   rem_next;
            logic [IDX_W:0]   rem_reg;
            logic [IDX_W-1:0] idx_next;
            logic [IDX_W-1:0] idx_reg;

            always_comb begin
                fold_next = '0;
                for (int b = 0; b < DIGITS; b++) begin
                    fold_next = fold_next +
                                V_W'(key[8*b +: 8]) * V_W'(WEIGHTS[IDX_W*b +: IDX_W]);
                end
                prod      = (2*V_W)'(fold_reg) * (2*V_W)'(RECIP);
                quot_next = prod[2*V_W-1:V_W];
                qm        = quot_reg * V_W'(ENTRIES);
                rem_next  = (IDX_W + 1)'(fold_reg - qm);
                if (rem_reg >= (IDX_W + 1)'(ENTRIES)) begin
                    idx_next = IDX_W'(rem_reg - (IDX_W + 1)'(ENTRIES));
                end else begin
                    idx_next = rem_reg[IDX_W-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    s1_reg   <= 1'b0;
                    s2_reg   <= 1'b0;
                    s3_reg   <= 1'b0;
                    done_reg <= 1'b0;
                end else begin
                    s1_reg   <= start;
                    s2_reg   <= s1_reg;
                    s3_reg   <= s2_reg;
                    done_reg <= s3_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    fold_reg <= fold_next;
                end
                if (s1_reg) begin
                    quot_reg <= quot_next;
                end
                if (s2_reg) begin
                    rem_reg <= rem_next;
                end
                if (s3_reg) begin
                    idx_reg <= idx_next;
                end
            end

            assign done  = done_reg;
            assign index = idx_reg;
        end
    endgenerate

endmodule

FILE: design/tt_mem.sv
module tt_mem
    import tt_pkg::*;
#(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output tt_entry_t         rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  tt_entry_t         wr_data
);

    tt_entry_t mem [DEPTH];
    tt_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/tt_update.sv
module tt_update
    import tt_pkg::*;
(
    input  tt_cfg_t   cfg,
    input  logic      opcode,
    input  tt_req_t   req,
    input  tt_entry_t entry,
    output tt_rsp_t   rsp,
    output logic      wr_en,
    output tt_entry_t wr_entry
);

    logic               match;
    logic               current;
    logic               cut_ok;
    logic               hit;
    logic signed [17:0] thr_s;
    logic signed [17:0] ply_s;
    logic signed [17:0] p0;
    logic signed [17:0] p1;
    logic signed [17:0] p2;
    logic signed [15:0] probe_s;
    logic signed [17:0] w0;
    logic signed [15:0] w1;
    logic signed [17:0] w1x;
    logic signed [15:0] w2;
    logic [1:0]         bound_new;

    always_comb begin
        thr_s   = $signed({3'b000, cfg.mate_thr});
        ply_s   = $signed({11'd0, req.ply});
        match   = entry.key == req.key;
        current = entry.gen == cfg.generation;
        cut_ok  = match && current && (entry.depth >= req.depth) && !req.on_pv;

        // Stored scores are ply-relative; bring mate scores back to the root.
        p0 = 18'(entry.score);
        p1 = (p0 >= thr_s) ? p0 - ply_s : p0;
        p2 = (p1 <= -thr_s) ? p1 + ply_s : p1;
        probe_s = sat16(p2);

        case (entry.bound)
            BOUND_EXACT: hit = 1'b1;
            BOUND_UPPER: hit = probe_s <= req.alpha;
            BOUND_LOWER: hit = probe_s >= req.beta;
            default:     hit = 1'b0;
        endcase

        w0  = 18'(req.score_in);
        w1  = (w0 >= thr_s) ? sat16(w0 + ply_s) : req.score_in;
        w1x = 18'(w1);
        w2  = (w1x <= -thr_s) ? sat16(w1x - ply_s) : w1;

        if (req.score_in <= req.alpha) begin
            bound_new = BOUND_UPPER;
        end else if (req.score_in >= req.beta) begin
            bound_new = BOUND_LOWER;
        end else begin
            bound_new = BOUND_EXACT;
        end

        wr_en = (opcode == OP_STORE) && !req.unsafe &&
                (!current || (req.depth >= entry.depth));

        wr_entry.key   = req.key;
        wr_entry.move  = req.move_in;
        wr_entry.depth = req.depth;
        wr_entry.gen   = cfg.generation;
        wr_entry.score = w2;
        wr_entry.bound = bound_new;

        rsp = '0;
        if (opcode == OP_PROBE) begin
            rsp.key_match  = match;
            rsp.move_valid = match && current;
            rsp.move_out   = (match && current) ? entry.move : 16'd0;
            rsp.cutoff     = cut_ok && hit;
            rsp.cutoff_score = (cut_ok && hit) ? probe_s : 16'sd0;
        end else begin
            rsp.written = wr_en;
        end
    end

endmodule

FILE: design/transposition_table_probe_store_core.sv
// Channel   Dir  Beat contents
// s_axis    in   tuser: opcode; tdata: probe or store request
// m_axis    out  tdata: one result per request
// cfg       in   cfg_we / cfg_index / cfg_wdata register writes
//
// With a power-of-two table a request steps through accept, index and
// memory read, evaluate and write back; other sizes add steps for the
// key remainder (byte fold, reciprocal multiply, subtract and correction).
// The simple dual-port table memory is read once per request and, outside
// the clearing pass, written only by a store that replaces its entry. After
// reset a clearing pass writes zero to every entry with s_axis_tready low.
// A held result stalls the evaluate step until m_axis_tready takes it.
module transposition_table_probe_store_core
    import tt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16384
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key, depth, ply, alpha, beta, on_pv, move_in, score_in, unsafe, zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [USER_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // key_match, move_valid, move_out, cutoff, cutoff_score, written, zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_INDEX = 4'b0100,
        S_EVAL  = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [7:0]       gen_reg;
    logic [14:0]      mate_thr_reg;
    tt_req_t          req_reg;
    logic             opcode_reg;
    logic             out_valid_reg;
    tt_rsp_t          out_rsp_reg;

    tt_cfg_t          cfg;
    logic             s_fire;
    logic             eval_fire;
    logic             idx_done;
    logic [IDX_W-1:0] idx;
    logic             rd_en;
    tt_entry_t        rd_entry;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    tt_entry_t        mem_wdata;
    tt_rsp_t          upd_rsp;
    logic             upd_we;
    tt_entry_t        upd_entry;

    assign cfg.generation = gen_reg;
    assign cfg.mate_thr   = mate_thr_reg;
    assign s_axis_tready  = state_reg == S_IDLE;
    assign s_fire         = s_axis_tvalid && s_axis_tready;
    assign eval_fire      = (state_reg == S_EVAL) && (!out_valid_reg || m_axis_tready);
    assign rd_en          = (state_reg == S_INDEX) && idx_done;

    tt_slot_map #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_index (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_fire),
        .key     (s_axis_tdata[KEY_W-1:0]),
        .done    (idx_done),
        .index   (idx)
    );

    always_comb begin
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = eval_fire && upd_we;
            mem_waddr = idx;
            mem_wdata = upd_entry;
        end
    end

    tt_mem #(
        .DEPTH   (TABLE_ENTRIES),
        .ADDR_W  (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (idx),
        .rd_data (rd_entry),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    tt_update u_update (
        .cfg      (cfg),
        .opcode   (opcode_reg),
        .req      (req_reg),
        .entry    (rd_entry),
        .rsp      (upd_rsp),
        .wr_en    (upd_we),
        .wr_entry (upd_entry)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_INDEX;
                end
            end
            S_INDEX: begin
                if (idx_done) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (eval_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            gen_reg       <= GEN_RESET;
            mate_thr_reg  <= MATE_THR_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_GENERATION: gen_reg      <= cfg_wdata[7:0];
                    REG_MATE_THR:   mate_thr_reg <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (eval_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg    <= tt_req_t'(s_axis_tdata[REQ_W-1:0]);
            opcode_reg <= s_axis_tuser[0];
        end
        if (eval_fire) begin
            out_rsp_reg <= upd_rsp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_rsp_reg);

endmodule

FILE: design/tt_checker.sv
`include "assert_macros.svh"

module tt_checker
    import tt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    tt_rsp_t rsp;

    assign rsp = tt_rsp_t'(m_axis_tdata[RSP_W-1:0]);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Stalled result changed.")
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "Request accepted while another is in flight.")
    `ASSERT_IMPLY(a_store_clean, aclk, aresetn, m_axis_tvalid && rsp.written, !rsp.key_match && !rsp.move_valid && !rsp.cutoff && rsp.move_out == 16'd0 && rsp.cutoff_score == 16'sd0, "Store result carries probe fields.")
    `ASSERT_IMPLY(a_probe_chain, aclk, aresetn, m_axis_tvalid, (!rsp.move_valid || rsp.key_match) && (!rsp.cutoff || rsp.move_valid), "Probe flags are inconsistent.")

endmodule

bind transposition_table_probe_store_core tt_checker u_tt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/tb_transposition_table_probe_store_core.sv
module tb_transposition_table_probe_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tt_pkg::*;

    localparam int SLOTS       = 16384;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 10;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 128;

    typedef struct {
        logic    op;
        tt_req_t req;
    } tt_cmd_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [USER_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    tt_cmd_t pending_reqs[$];
    tt_rsp_t expected_rsps[$];

    logic [63:0] tbl_key   [SLOTS];
    logic [15:0] tbl_move  [SLOTS];
    logic [5:0]  tbl_depth [SLOTS];
    logic [7:0]  tbl_gen   [SLOTS];
    int          tbl_score [SLOTS];
    logic [1:0]  tbl_bound [SLOTS];

    logic [7:0]  shadow_gen = GEN_RESET;
    logic [14:0] shadow_thr = MATE_THR_RESET;
    logic [49:0] key_tags[4];

    int   mismatches  = 0;
    int   cycles      = 0;
    int   tx_wait     = 0;
    int   rx_wait     = 0;
    logic tx_idle_on  = 1'b1;
    logic rx_idle_on  = 1'b1;
    logic hold_go     = 1'b0;
    logic hold_active = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_cnt    = 0;

    transposition_table_probe_store_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int clip16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic tt_rsp_t table_access(logic op, tt_req_t r);
        tt_rsp_t o;
        int      slot;
        int      s;
        int      ply_v;
        int      thr;
        int      alpha_v;
        int      beta_v;
        int      score_v;
        logic    current;
        logic    hit;
        o       = '0;
        slot    = int'(r.key % 64'(SLOTS));
        ply_v   = int'(r.ply);
        thr     = int'(shadow_thr);
        alpha_v = r.alpha;
        beta_v  = r.beta;
        score_v = r.score_in;
        if (op == OP_PROBE) begin
            if (tbl_key[slot] == r.key) begin
                o.key_match = 1'b1;
                current = (tbl_gen[slot] == shadow_gen);
                if (current) begin
                    o.move_valid = 1'b1;
                    o.move_out   = tbl_move[slot];
                end
                if (current && tbl_depth[slot] >= r.depth && !r.on_pv) begin
                    s = tbl_score[slot];
                    if (s >= thr) s = s - ply_v;
                    if (s <= -thr) s = s + ply_v;
                    s = clip16(s);
                    hit = (tbl_bound[slot] == BOUND_EXACT) ||
                          (tbl_bound[slot] == BOUND_UPPER && s <= alpha_v) ||
                          (tbl_bound[slot] == BOUND_LOWER && s >= beta_v);
                    if (hit) begin
                        o.cutoff       = 1'b1;
                        o.cutoff_score = 16'(s);
                    end
                end
            end
        end else if (!r.unsafe) begin
            if (tbl_gen[slot] != shadow_gen || r.depth >= tbl_depth[slot]) begin
                s = score_v;
                if (s >= thr) s = clip16(s + ply_v);
                if (s <= -thr) s = clip16(s - ply_v);
                tbl_key[slot]   = r.key;
                tbl_move[slot]  = r.move_in;
                tbl_depth[slot] = r.depth;
                tbl_gen[slot]   = shadow_gen;
                tbl_score[slot] = s;
                if (score_v <= alpha_v) begin
                    tbl_bound[slot] = BOUND_UPPER;
                end else if (score_v >= beta_v) begin
                    tbl_bound[slot] = BOUND_LOWER;
                end else begin
                    tbl_bound[slot] = BOUND_EXACT;
                end
                o.written = 1'b1;
            end
        end
        return o;
    endfunction

    function automatic int pick_score(int thr);
        int v;
        case ($urandom_range(0, 5))
            0: v = int'($signed(16'($urandom)));
            1: v = thr + int'($urandom_range(0, 130));
            2: v = -(thr + int'($urandom_range(0, 130)));
            3: v = ($urandom_range(0, 1) == 0) ? 32767 : -32768;
            4: v = int'($urandom_range(0, 100)) - 50;
            default: v = thr - int'($urandom_range(0, 130));
        endcase
        return clip16(v);
    endfunction

    function automatic tt_cmd_t random_cmd();
        tt_cmd_t     c;
        int          thr;
        logic [13:0] slot;
        thr  = int'(shadow_thr);
        slot = ($urandom_range(0, 4) == 0) ? 14'h3fff : 14'($urandom_range(0, 15));
        c.op = ($urandom_range(0, 1) == 0) ? OP_PROBE : OP_STORE;
        if ($urandom_range(0, 99) < 15) begin
            c.req.key = {$urandom, $urandom};
        end else begin
            c.req.key = {key_tags[$urandom_range(0, 3)], slot};
        end
        c.req.depth    = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 8));
        c.req.ply      = 7'($urandom_range(0, 127));
        c.req.alpha    = 16'(pick_score(thr));
        c.req.beta     = 16'(pick_score(thr));
        c.req.on_pv    = ($urandom_range(0, 3) == 0);
        c.req.move_in  = 16'($urandom);
        c.req.score_in = 16'(pick_score(thr));
        c.req.unsafe   = ($urandom_range(0, 6) == 0);
        return c;
    endfunction

    task automatic push_req(input logic op, input logic [63:0] key, input int depth,
                            input int ply, input int alpha, input int beta,
                            input logic on_pv, input int move, input int score,
                            input logic unsafe);
        tt_cmd_t c;
        c.op           = op;
        c.req.key      = key;
        c.req.depth    = 6'(depth);
        c.req.ply      = 7'(ply);
        c.req.alpha    = 16'(alpha);
        c.req.beta     = 16'(beta);
        c.req.on_pv    = on_pv;
        c.req.move_in  = 16'(move);
        c.req.score_in = 16'(score);
        c.req.unsafe   = unsafe;
        pending_reqs.push_back(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        if (idx == REG_GENERATION) begin
            shadow_gen = 8'(val);
        end else begin
            shadow_thr = 15'(val);
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : request_driver
        tt_cmd_t cmd;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_wait       <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_rsps.push_back(table_access(s_axis_tuser[0],
                                                     tt_req_t'(s_axis_tdata[REQ_W-1:0])));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait != 0) begin
                    tx_wait       <= tx_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cmd = pending_reqs.pop_front();
                    s_axis_tdata  <= S_TDATA_W'(cmd.req);
                    s_axis_tuser  <= cmd.op;
                    s_axis_tvalid <= 1'b1;
                    tx_wait       <= tx_idle_on ? int'($urandom_range(0, 6)) : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        tt_rsp_t got;
        tt_rsp_t want;
        int      w;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = tt_rsp_t'(m_axis_tdata[RSP_W-1:0]);
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result with no request pending: %h", got);
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.key_match !== want.key_match || got.move_valid !== want.move_valid ||
                        got.move_out !== want.move_out || got.cutoff !== want.cutoff ||
                        got.cutoff_score !== want.cutoff_score ||
                        got.written !== want.written) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch (expected/actual): key_match %b/%b ",
                                     want.key_match, got.key_match,
                                     "move_valid %b/%b move_out %h/%h ",
                                     want.move_valid, got.move_valid,
                                     want.move_out, got.move_out,
                                     "cutoff %b/%b score %0d/%0d written %b/%b",
                                     want.cutoff, got.cutoff,
                                     want.cutoff_score, got.cutoff_score,
                                     want.written, got.written);
                        end
                    end
                end
                w = rx_idle_on ? int'($urandom_range(0, 6)) : 0;
                rx_wait       <= w;
                m_axis_tready <= (w == 0) && !hold_active;
            end else if (rx_wait != 0) begin
                rx_wait       <= rx_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !hold_active;
            end
        end
    end

    always @(posedge aclk) begin : result_hold
        if (!aresetn) begin
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
            hold_cnt    <= 0;
        end else if (hold_go && !hold_done) begin
            if (hold_cnt == HOLD_CYCLES) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end else begin
                hold_active <= 1'b1;
                hold_cnt    <= hold_cnt + 1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int          i;
        int          p;
        int          thr;
        int          gen_plan[PHASES];
        int          thr_plan[PHASES];
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        gen_plan = '{255, 255, 0, 1, 1, 7, 7, 0};
        thr_plan = '{0, 32767, 31900, 100, 32767, 0, -1, 1};
        key_a = 64'hA5A5_0000_1234_0003;
        key_b = 64'h5A5A_FFFF_0000_0003;
        key_c = 64'hFFFF_FFFF_FFFF_FFFF;
        for (i = 0; i < SLOTS; i++) begin
            tbl_key[i]   = '0;
            tbl_move[i]  = '0;
            tbl_depth[i] = '0;
            tbl_gen[i]   = '0;
            tbl_score[i] = 0;
            tbl_bound[i] = BOUND_EXACT;
        end
        key_tags[0] = '0;
        for (i = 1; i < 4; i++) begin
            key_tags[i] = 50'({$urandom, $urandom});
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // A cleared slot matches key zero with an exact bound of score zero.
        push_req(OP_PROBE, 64'h0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        push_req(OP_PROBE, 64'h0, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0);
        push_req(OP_PROBE, 64'h0, 63, 127, -32768, 32767, 1'b0, 0, 0, 1'b0);
        push_req(OP_PROBE, key_c, 0, 0, 0, 0, 1'b0, 65535, -1, 1'b1);
        push_req(OP_STORE, key_a, 63, 127, -32768, 32767, 1'b0, 65535, 32767, 1'b1);
        push_req(OP_PROBE, key_a, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        push_req(OP_STORE, key_a, 63, 127, -32768, 32767, 1'b1, 65535, 32767, 1'b0);
        push_req(OP_PROBE, key_a, 63, 127, -32768, 32767, 1'b0, 0, 0, 1'b0);
        push_req(OP_PROBE, key_a, 0, 127, 32767, -32768, 1'b0, 0, 0, 1'b0);
        push_req(OP_STORE, key_b, 10, 0, 0, 100, 1'b0, 4660, 50, 1'b0);
        push_req(OP_STORE, key_b, 63, 127, 0, 100, 1'b0, 22136, -32768, 1'b0);
        push_req(OP_PROBE, key_a, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        push_req(OP_PROBE, key_b, 20, 127, 0, 100, 1'b0, 0, 0, 1'b0);
        push_req(OP_PROBE, key_b, 20, 127, -32768, 100, 1'b0, 0, 0, 1'b0);
        push_req(OP_STORE, key_c, 0, 3, 0, 100, 1'b0, 1, 50, 1'b0);
        push_req(OP_PROBE, key_c, 0, 3, 0, 100, 1'b0, 0, 0, 1'b0);
        push_req(OP_PROBE, key_c, 1, 3, 0, 100, 1'b0, 0, 0, 1'b0);
        push_req(OP_STORE, key_c, 5, 0, 0, 100, 1'b0, 2, 100, 1'b0);
        push_req(OP_PROBE, key_c, 5, 0, 0, 101, 1'b0, 0, 0, 1'b0);
        push_req(OP_PROBE, key_c, 5, 0, 0, 100, 1'b0, 0, 0, 1'b0);
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            thr = (thr_plan[p] < 0) ? int'($urandom_range(0, 32767)) : thr_plan[p];
            write_reg(REG_GENERATION, gen_plan[p]);
            write_reg(REG_MATE_THR, thr);
            tx_idle_on = (p % 3 != 2) && (p != 4);
            rx_idle_on = (p % 4 != 3);
            if (p == 0) begin
                // Entries from generation zero are now stale and replaceable by any store not marked unsafe.
                push_req(OP_PROBE, key_a, 0, 0, -32768, 32767, 1'b0, 0, 0, 1'b0);
                push_req(OP_STORE, key_b, 0, 5, 0, 0, 1'b0, 77, 0, 1'b0);
                push_req(OP_PROBE, key_b, 0, 5, 0, 0, 1'b0, 0, 0, 1'b0);
            end
            if (p == 4) begin
                hold_go = 1'b1;
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                pending_reqs.push_back(random_cmd());
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
